>>> sv/slmd_pkg.sv
// Package for the sorted list merge and dedup unit.
// Holds the request and result types, the list depth and the command codes.
// No dependencies.
package slmd_pkg;

   // Number of entries in each list store.
   localparam int LIST_DEPTH = 32;

   // Width of an entry count, able to hold LIST_DEPTH itself.
   localparam int CNT_W = $clog2(LIST_DEPTH + 1);

   // Width of a store address.
   localparam int ADDR_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

   // Width of one stored element.
   localparam int DATA_W = 32;

   // Command codes.
   localparam logic [1:0] CMD_APPEND_A = 2'd0;
   localparam logic [1:0] CMD_APPEND_B = 2'd1;
   localparam logic [1:0] CMD_MERGE    = 2'd2;

   // One request.
   typedef struct packed {
      logic [1:0]         cmd;
      logic signed [31:0] value;
   } req_type;

   // One result.
   typedef struct packed {
      logic signed [31:0] merged_value;
      logic               is_last;
      logic               is_empty;
      logic               overflowed;
   } rsp_type;

endpackage

>>> sv/slmd_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; used for both list stores.
module slmd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/sorted_list_merge_dedup_unit.sv
// Top level of the sorted list merge and dedup unit.
// Depends on slmd_pkg and slmd_ram (one instance per list store).
//
// Channel   Ports                    Handshake
// request   start, busy, req_data    taken when start is high and busy is low
// result    rsp_valid, rsp_data      each result valid for a single cycle, no back pressure
//
// An append leaves busy low; a new request may follow in the next cycle.
// A merge of non-empty lists keeps busy high until its last result is given;
// it gives at most 2 x LIST_DEPTH results, and each store is read once per
// cycle. A merge of two empty lists gives its single result in the next
// cycle with busy never raised. Reset clears counts, the overflow flag and
// the state; store contents are left as they are.
module sorted_list_merge_dedup_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  slmd_pkg::req_type req_data,
   output logic              rsp_valid,
   output slmd_pkg::rsp_type rsp_data
);

   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_MERGE = 1'b1;

   logic                        state_ff, state_in;
   logic [slmd_pkg::CNT_W-1:0]  cnt_a_ff, cnt_a_in;
   logic [slmd_pkg::CNT_W-1:0]  cnt_b_ff, cnt_b_in;
   logic [slmd_pkg::CNT_W-1:0]  ia_ff, ia_in;
   logic [slmd_pkg::CNT_W-1:0]  ib_ff, ib_in;
   logic                        ovf_ff, ovf_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   slmd_pkg::rsp_type           rsp_data_ff, rsp_data_in;

   logic                        accept;
   logic                        wr_a, wr_b;
   logic [slmd_pkg::DATA_W-1:0] head_a, head_b;
   logic                        a_ok, b_ok;
   logic                        last;
   logic [slmd_pkg::CNT_W-1:0]  ia_adv, ib_adv;
   logic [slmd_pkg::DATA_W-1:0] pick;

   assign accept = start && !busy;
   assign busy   = (state_ff == ST_MERGE);

   // The list stores; the read address follows the next head index so the
   // head values are ready in the next cycle.
   slmd_ram #(
      .WIDTH (slmd_pkg::DATA_W),
      .DEPTH (slmd_pkg::LIST_DEPTH)
   ) u_ram_a (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (cnt_a_ff[slmd_pkg::ADDR_W-1:0]),
      .wr_data (req_data.value),
      .rd_addr (ia_in[slmd_pkg::ADDR_W-1:0]),
      .rd_data (head_a)
   );

   slmd_ram #(
      .WIDTH (slmd_pkg::DATA_W),
      .DEPTH (slmd_pkg::LIST_DEPTH)
   ) u_ram_b (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (cnt_b_ff[slmd_pkg::ADDR_W-1:0]),
      .wr_data (req_data.value),
      .rd_addr (ib_in[slmd_pkg::ADDR_W-1:0]),
      .rd_data (head_b)
   );

   assign a_ok = (ia_ff < cnt_a_ff);
   assign b_ok = (ib_ff < cnt_b_ff);

   // Head compare: pick the smaller head; equal heads give one copy and
   // both advance; when one list is used up, the other's head is taken.
   always_comb begin
      ia_adv = ia_ff;
      ib_adv = ib_ff;
      pick   = head_b;
      if (a_ok && b_ok) begin
         if ($signed(head_a) < $signed(head_b)) begin
            pick   = head_a;
            ia_adv = ia_ff + 1'b1;
         end else if ($signed(head_b) < $signed(head_a)) begin
            pick   = head_b;
            ib_adv = ib_ff + 1'b1;
         end else begin
            pick   = head_a;
            ia_adv = ia_ff + 1'b1;
            ib_adv = ib_ff + 1'b1;
         end
      end else if (a_ok) begin
         pick   = head_a;
         ia_adv = ia_ff + 1'b1;
      end else begin
         pick   = head_b;
         ib_adv = ib_ff + 1'b1;
      end
   end

   assign last = (ia_adv >= cnt_a_ff) && (ib_adv >= cnt_b_ff);

   // Request decode and the merge walk.
   always_comb begin
      state_in     = state_ff;
      cnt_a_in     = cnt_a_ff;
      cnt_b_in     = cnt_b_ff;
      ia_in        = '0;
      ib_in        = '0;
      ovf_in       = ovf_ff;
      wr_a         = 1'b0;
      wr_b         = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_data.cmd)
                  slmd_pkg::CMD_APPEND_A: begin
                     if (cnt_a_ff < slmd_pkg::CNT_W'(slmd_pkg::LIST_DEPTH)) begin
                        wr_a     = 1'b1;
                        cnt_a_in = cnt_a_ff + 1'b1;
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  slmd_pkg::CMD_APPEND_B: begin
                     if (cnt_b_ff < slmd_pkg::CNT_W'(slmd_pkg::LIST_DEPTH)) begin
                        wr_b     = 1'b1;
                        cnt_b_in = cnt_b_ff + 1'b1;
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  slmd_pkg::CMD_MERGE: begin
                     if (cnt_a_ff == '0 && cnt_b_ff == '0) begin
                        // Both lists empty: one flagged result, with no merge walk.
                        rsp_valid_in             = 1'b1;
                        rsp_data_in.merged_value = '0;
                        rsp_data_in.is_last      = 1'b1;
                        rsp_data_in.is_empty     = 1'b1;
                        rsp_data_in.overflowed   = ovf_ff;
                        ovf_in                   = 1'b0;
                     end else begin
                        state_in = ST_MERGE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_MERGE: begin
            // Emit the picked head and step the indices.
            ia_in                    = ia_adv;
            ib_in                    = ib_adv;
            rsp_data_in.merged_value = pick;
            rsp_valid_in             = 1'b1;
            rsp_data_in.is_last      = last;
            rsp_data_in.is_empty     = 1'b0;
            rsp_data_in.overflowed   = ovf_ff;

            // End of the run: clear the lists and go back to idle.
            if (last) begin
               ia_in    = '0;
               ib_in    = '0;
               cnt_a_in = '0;
               cnt_b_in = '0;
               ovf_in   = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_a_ff     <= '0;
         cnt_b_ff     <= '0;
         ia_ff        <= '0;
         ib_ff        <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_a_ff     <= cnt_a_in;
         cnt_b_ff     <= cnt_b_in;
         ia_ff        <= ia_in;
         ib_ff        <= ib_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload register.
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> tb/sv/sorted_list_merge_dedup_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for sorted_list_merge_dedup_unit.
// Depends on slmd_pkg and the unit's RTL; it issues append and merge requests
// and checks every result against a merge predictor kept in this file.
module sorted_list_merge_dedup_unit_tb;

   localparam int          STALL_LIMIT  = 2000;
   localparam int          ITEM_GOAL    = 110;
   localparam int          QUIET_FIRST  = 40;
   localparam int          QUIET_LAST   = 80;
   localparam logic [1:0]  CMD_UNUSED   = 2'd3;
   localparam logic signed [31:0] MIN_VAL = 32'sh8000_0000;
   localparam logic signed [31:0] MAX_VAL = 32'sh7fff_ffff;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic              rsp_valid;
   slmd_pkg::req_type req_data;
   slmd_pkg::rsp_type rsp_data;

   // Requests waiting to be issued and merge results still owed by the unit.
   slmd_pkg::req_type pending_reqs[$];
   slmd_pkg::rsp_type merge_results_due[$];

   // Predicted state of the two list stores.
   logic signed [31:0] list_a_vals [slmd_pkg::LIST_DEPTH];
   logic signed [31:0] list_b_vals [slmd_pkg::LIST_DEPTH];
   int   len_a = 0;
   int   len_b = 0;
   logic dropped_append = 1'b0;

   int n_issued = 0;
   int n_accepted = 0;
   int stim_count = 0;
   int error_count = 0;
   int stall_cycles = 0;

   sorted_list_merge_dedup_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // Free-running 10 ns clock.
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Print one mismatch line and count it.
   task automatic note_mismatch(input string msg);
      $display("%0t ns mismatch: %s", $time, msg);
      error_count++;
   endtask

   // Update the list model for one accepted request and queue any results.
   task automatic apply_list_request(input slmd_pkg::req_type r);
      int                 ia;
      int                 ib;
      logic signed [31:0] pick;
      slmd_pkg::rsp_type  res;
      ia = 0;
      ib = 0;
      case (r.cmd)
         slmd_pkg::CMD_APPEND_A: begin
            if (len_a < slmd_pkg::LIST_DEPTH) begin
               list_a_vals[len_a] = r.value;
               len_a++;
            end else begin
               dropped_append = 1'b1;
            end
         end
         slmd_pkg::CMD_APPEND_B: begin
            if (len_b < slmd_pkg::LIST_DEPTH) begin
               list_b_vals[len_b] = r.value;
               len_b++;
            end else begin
               dropped_append = 1'b1;
            end
         end
         slmd_pkg::CMD_MERGE: begin
            if (len_a == 0 && len_b == 0) begin
               res.merged_value = '0;
               res.is_last = 1'b1;
               res.is_empty = 1'b1;
               res.overflowed = dropped_append;
               merge_results_due.push_back(res);
            end
            // Head-compare walk; equal heads give one copy and both advance.
            while (ia < len_a || ib < len_b) begin
               if (ia < len_a && ib < len_b) begin
                  if (list_a_vals[ia] < list_b_vals[ib]) begin
                     pick = list_a_vals[ia];
                     ia++;
                  end else if (list_b_vals[ib] < list_a_vals[ia]) begin
                     pick = list_b_vals[ib];
                     ib++;
                  end else begin
                     pick = list_a_vals[ia];
                     ia++;
                     ib++;
                  end
               end else if (ia < len_a) begin
                  pick = list_a_vals[ia];
                  ia++;
               end else begin
                  pick = list_b_vals[ib];
                  ib++;
               end
               res.merged_value = pick;
               res.is_last = (ia >= len_a && ib >= len_b);
               res.is_empty = 1'b0;
               res.overflowed = dropped_append;
               merge_results_due.push_back(res);
            end
            len_a = 0;
            len_b = 0;
            dropped_append = 1'b0;
         end
         default: ;
      endcase
   endtask

   // Compare one result with the oldest one owed.
   task automatic check_merge_result(input slmd_pkg::rsp_type got);
      slmd_pkg::rsp_type want;
      if (merge_results_due.size() == 0) begin
         note_mismatch($sformatf("result %0d with none pending", got.merged_value));
      end else begin
         want = merge_results_due.pop_front();
         // The value carries no meaning on an empty merge.
         if (!want.is_empty && got.merged_value !== want.merged_value) begin
            note_mismatch($sformatf("merged_value %0d, predicted %0d",
                                    got.merged_value, want.merged_value));
         end
         if (got.is_last !== want.is_last) begin
            note_mismatch($sformatf("is_last %b, predicted %b", got.is_last, want.is_last));
         end
         if (got.is_empty !== want.is_empty) begin
            note_mismatch($sformatf("is_empty %b, predicted %b", got.is_empty, want.is_empty));
         end
         if (got.overflowed !== want.overflowed) begin
            note_mismatch($sformatf("overflowed %b, predicted %b",
                                    got.overflowed, want.overflowed));
         end
      end
   endtask

   // Queue one request for the driver.
   task automatic add_req(input logic [1:0] cmd, input logic signed [31:0] value);
      slmd_pkg::req_type r;
      r.cmd = cmd;
      r.value = value;
      pending_reqs.push_back(r);
      if (cmd != CMD_UNUSED) begin
         stim_count++;
      end
   endtask

   // Queue appends for two lists, interleaved at random with rare unused
   // commands, then a merge. A spread of zero draws full-range values, else
   // values crowd near one base: equal heads and in-list duplicates are common.
   task automatic add_list_pair(input int na, input int nb, input int spread,
                                input bit sorted);
      logic signed [31:0] qa[$];
      logic signed [31:0] qb[$];
      logic signed [31:0] base;
      logic signed [31:0] v;
      int                 pos;
      base = $urandom;
      for (int i = 0; i < na + nb; i++) begin
         v = (spread == 0) ? $urandom : base + $urandom_range(spread, 0);
         pos = 0;
         if (i < na) begin
            if (sorted) begin
               while (pos < qa.size() && qa[pos] <= v) pos++;
            end else begin
               pos = qa.size();
            end
            qa.insert(pos, v);
         end else begin
            if (sorted) begin
               while (pos < qb.size() && qb[pos] <= v) pos++;
            end else begin
               pos = qb.size();
            end
            qb.insert(pos, v);
         end
      end
      while (qa.size() > 0 || qb.size() > 0) begin
         if ($urandom_range(99, 0) < 4) begin
            add_req(CMD_UNUSED, $urandom);
         end
         if (qb.size() == 0 || (qa.size() > 0 && $urandom_range(1, 0) == 0)) begin
            add_req(slmd_pkg::CMD_APPEND_A, qa.pop_front());
         end else begin
            add_req(slmd_pkg::CMD_APPEND_B, qb.pop_front());
         end
      end
      add_req(slmd_pkg::CMD_MERGE, $urandom);
   endtask

   // Directed requests followed by random list pairs.
   task automatic build_stimulus();
      int pick;
      int na;
      int nb;
      int spread;
      // Merge with both lists empty.
      add_req(slmd_pkg::CMD_MERGE, MAX_VAL);
      // Field extremes, equal heads at both ends, and an ignored command.
      add_req(slmd_pkg::CMD_APPEND_A, MIN_VAL);
      add_req(slmd_pkg::CMD_APPEND_A, -32'sd1);
      add_req(slmd_pkg::CMD_APPEND_A, 32'sd0);
      add_req(slmd_pkg::CMD_APPEND_A, MAX_VAL);
      add_req(slmd_pkg::CMD_APPEND_B, MIN_VAL);
      add_req(slmd_pkg::CMD_APPEND_B, 32'sd0);
      add_req(slmd_pkg::CMD_APPEND_B, 32'sd7);
      add_req(slmd_pkg::CMD_APPEND_B, MAX_VAL);
      add_req(CMD_UNUSED, -32'sd1);
      add_req(slmd_pkg::CMD_MERGE, MIN_VAL);
      // Duplicates inside list A only, with B empty.
      add_req(slmd_pkg::CMD_APPEND_A, 32'sd5);
      add_req(slmd_pkg::CMD_APPEND_A, 32'sd5);
      add_req(slmd_pkg::CMD_MERGE, 32'sd0);
      // List B only.
      add_req(slmd_pkg::CMD_APPEND_B, -32'sd3);
      add_req(slmd_pkg::CMD_APPEND_B, 32'sd9);
      add_req(slmd_pkg::CMD_MERGE, -32'sd1);
      // Unsorted contents still take the head-compare walk.
      add_req(slmd_pkg::CMD_APPEND_A, 32'sd10);
      add_req(slmd_pkg::CMD_APPEND_A, 32'sd3);
      add_req(slmd_pkg::CMD_APPEND_B, 32'sd5);
      add_req(slmd_pkg::CMD_MERGE, 32'sd0);
      // Back-to-back merge finds both lists empty again.
      add_req(slmd_pkg::CMD_MERGE, 32'sd0);

      // Both stores overfilled: dropped appends and the longest merge.
      add_list_pair(slmd_pkg::LIST_DEPTH + 1, slmd_pkg::LIST_DEPTH + 2, 0, 1'b1);
      while (stim_count < ITEM_GOAL) begin
         pick = $urandom_range(9, 0);
         na = $urandom_range(6, 0);
         nb = $urandom_range(6, 0);
         if (pick == 0) begin
            na = 0;
            nb = 0;
         end
         spread = (pick < 5) ? 0 : $urandom_range(12, 1);
         add_list_pair(na, nb, spread, pick != 9);
      end
   endtask

   // Driver: presents requests at the falling edge, holding each until taken.
   always @(negedge clock) begin
      if (!reset && n_accepted == n_issued) begin
         if (pending_reqs.size() > 0 &&
             ((n_issued >= QUIET_FIRST && n_issued < QUIET_LAST) ||
              $urandom_range(99, 0) >= 16)) begin
            req_data <= pending_reqs.pop_front();
            start <= 1'b1;
            n_issued <= n_issued + 1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: checks results, records accepted requests, and runs the watchdog.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            check_merge_result(rsp_data);
         end
         if (start && !busy) begin
            apply_list_request(req_data);
            n_accepted <= n_accepted + 1;
         end
         if (rsp_valid || (start && !busy)) begin
            stall_cycles <= 0;
         end else if (stall_cycles + 1 >= STALL_LIMIT) begin
            $display("sorted_list_merge_dedup_unit regression: fail");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   // Reset, run all requests, drain results, and report.
   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      build_stimulus();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (pending_reqs.size() > 0 || n_accepted != n_issued ||
             merge_results_due.size() > 0) begin
         @(negedge clock);
      end
      // Catch any stray result after the last one owed.
      repeat (8) @(negedge clock);
      if (error_count == 0) begin
         $display("sorted_list_merge_dedup_unit regression: pass");
      end else begin
         $display("sorted_list_merge_dedup_unit regression: fail");
      end
      $finish;
   end

endmodule
